FILE: hdl/lrf_pkg.sv
package lrf_pkg;

   // default number of queue entries
   localparam int QUEUE_DEPTH_DEFAULT = 16;

   localparam int TIME_W  = 32;
   localparam int ID_W    = 8;
   localparam int BURST_W = 16;

   // request opcodes
   localparam logic OP_ARRIVE = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   // response status codes
   typedef enum logic [1:0] {
      STATUS_IDLE   = 2'd0,
      STATUS_RAN    = 2'd1,
      STATUS_ACCEPT = 2'd2,
      STATUS_REJECT = 2'd3
   } status_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_FIRST,
      ST_SCAN,
      ST_SHIFT,
      ST_FINISH
   } state_type;

   // one queue entry as stored in the memory
   typedef struct packed {
      logic [TIME_W-1:0]  arrival;
      logic [ID_W-1:0]    id;
      logic [BURST_W-1:0] remaining;
      logic [BURST_W-1:0] original;
   } entry_type;

endpackage

FILE: hdl/longest_remaining_first_scheduler.sv
// Arrival: result strobe in the cycle after start; busy stays low, next word the cycle after.
// Tick on empty queue: result in the cycle after start, busy stays low.
// Tick with n queued jobs: busy through the scan, compaction and finish states, paced by
// the one-entry-per-cycle read port of the queue memory (scan, then compaction).
// Reset (synchronous, active high) clears count, time, sequencer and strobe; queue memory
// contents are left undefined and never used before written. Receiver cannot stall results.
module longest_remaining_first_scheduler
   import lrf_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_opcode,
   input  logic [ID_W-1:0]    req_job_id,
   input  logic [BURST_W-1:0] req_burst_length,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [ID_W-1:0]    rsp_ran_job_id,
   output logic               rsp_first_service,
   output logic [TIME_W-1:0]  rsp_wait_time,
   output logic               rsp_finished,
   output logic [TIME_W-1:0]  rsp_turnaround_time
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   // control state
   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [TIME_W-1:0]   time_ff, time_in;
   logic [IDX_W-1:0]    rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]    cursor_ff, cursor_in;
   logic                pend_ff, pend_in;
   logic [IDX_W-1:0]    best_idx_ff, best_idx_in;
   entry_type           best_ff, best_in;

   // queue memory
   entry_type           mem [QUEUE_DEPTH];
   entry_type           rd_data_ff;
   logic [IDX_W-1:0]    rd_addr;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   entry_type           wr_data;

   // response registers
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic                rsp_first_ff, rsp_first_in;
   logic [TIME_W-1:0]   rsp_wait_ff, rsp_wait_in;
   logic                rsp_fin_ff, rsp_fin_in;
   logic [TIME_W-1:0]   rsp_turn_ff, rsp_turn_in;

   logic                accept;
   logic                take;
   logic                scan_last;
   logic [BURST_W-1:0]  rem_dec;
   logic [TIME_W-1:0]   wait_diff;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   // scan compare: visited entry takes over on greater or equal
   assign take      = (rd_data_ff.remaining >= best_ff.remaining);
   assign scan_last = (rd_idx_ff == IDX_W'(1));
   assign rem_dec   = (best_ff.remaining != '0) ? best_ff.remaining - BURST_W'(1)
                                                : best_ff.remaining;
   assign wait_diff = time_ff - best_ff.arrival;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_opcode == OP_TICK && count_ff != '0) begin
               state_in = ST_SCAN_FIRST;
            end
         end
         ST_SCAN_FIRST: begin
            state_in = (count_ff == CNT_W'(1)) ? ST_SHIFT : ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if (cursor_ff >= count_ff && !pend_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_in      = count_ff;
      time_in       = time_ff;
      rd_idx_in     = rd_idx_ff;
      cursor_in     = cursor_ff;
      pend_in       = 1'b0;
      best_idx_in   = best_idx_ff;
      best_in       = best_ff;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = rd_data_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = STATUS_IDLE;
      rsp_id_in     = '0;
      rsp_first_in  = 1'b0;
      rsp_wait_in   = '0;
      rsp_fin_in    = 1'b0;
      rsp_turn_in   = '0;
      case (state_ff)
         ST_IDLE: begin
            // entry 0 is fetched for a possible scan
            rd_addr = '0;
            if (accept) begin
               rsp_id_in = (req_opcode == OP_ARRIVE) ? req_job_id : '0;
               if (req_opcode == OP_ARRIVE) begin
                  rsp_valid_in = 1'b1;
                  if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
                     rsp_status_in = STATUS_REJECT;
                  end else begin
                     rsp_status_in   = STATUS_ACCEPT;
                     wr_en           = 1'b1;
                     wr_addr         = count_ff[IDX_W-1:0];
                     wr_data.arrival   = time_ff;
                     wr_data.id        = req_job_id;
                     wr_data.remaining = req_burst_length;
                     wr_data.original  = req_burst_length;
                     count_in        = count_ff + CNT_W'(1);
                  end
               end else if (count_ff == '0) begin
                  // empty queue: idle tick
                  rsp_valid_in = 1'b1;
                  time_in      = time_ff + TIME_W'(1);
               end
            end
         end
         ST_SCAN_FIRST: begin
            best_in     = rd_data_ff;
            best_idx_in = '0;
            cursor_in   = CNT_W'(1);
            rd_addr     = IDX_W'(count_ff - CNT_W'(1));
            rd_idx_in   = rd_addr;
         end
         ST_SCAN: begin
            if (take) begin
               best_in     = rd_data_ff;
               best_idx_in = rd_idx_ff;
            end
            cursor_in = CNT_W'(best_idx_in) + CNT_W'(1);
            rd_addr   = rd_idx_ff - IDX_W'(1);
            if (!scan_last) begin
               rd_idx_in = rd_addr;
            end
         end
         ST_SHIFT: begin
            // read entry j, write it to j-1 on the next cycle
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = rd_idx_ff - IDX_W'(1);
            end
            if (cursor_ff < count_ff) begin
               rd_addr   = cursor_ff[IDX_W-1:0];
               rd_idx_in = rd_addr;
               cursor_in = cursor_ff + CNT_W'(1);
               pend_in   = 1'b1;
            end
         end
         ST_FINISH: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_RAN;
            rsp_id_in     = best_ff.id;
            rsp_first_in  = (best_ff.remaining == best_ff.original);
            rsp_wait_in   = rsp_first_in ? wait_diff : '0;
            rsp_fin_in    = (rem_dec == '0);
            rsp_turn_in   = rsp_fin_in ? wait_diff + TIME_W'(1) : '0;
            time_in       = time_ff + TIME_W'(1);
            if (rsp_fin_in) begin
               count_in = count_ff - CNT_W'(1);
            end else begin
               // requeue at the tail
               wr_en             = 1'b1;
               wr_addr           = IDX_W'(count_ff - CNT_W'(1));
               wr_data           = best_ff;
               wr_data.remaining = rem_dec;
            end
         end
         default: begin
         end
      endcase
   end

   // queue memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         time_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         time_ff      <= time_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      cursor_ff     <= cursor_in;
      best_idx_ff   <= best_idx_in;
      best_ff       <= best_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_wait_ff   <= rsp_wait_in;
      rsp_fin_ff    <= rsp_fin_in;
      rsp_turn_ff   <= rsp_turn_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_ran_job_id      = rsp_id_ff;
   assign rsp_first_service   = rsp_first_ff;
   assign rsp_wait_time       = rsp_wait_ff;
   assign rsp_finished        = rsp_fin_ff;
   assign rsp_turnaround_time = rsp_turn_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count above depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |->
         (count_ff == $past(count_ff) + CNT_W'(1) || count_ff + CNT_W'(1) == $past(count_ff)))
      else $error("queue count moved by more than one");

   a_arrive_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && req_opcode == OP_ARRIVE) |=>
         (rsp_valid && (rsp_status == STATUS_ACCEPT || rsp_status == STATUS_REJECT)))
      else $error("arrival without its response");

   a_finish_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |=> (rsp_valid && rsp_status == STATUS_RAN && !busy))
      else $error("finished tick without run response");

endmodule
